@@ rtl/gheq_pkg.sv @@
// Package for the gray histogram equalizer.
// Holds the operation codes shared by the top level and its checker.
// No dependencies.
`timescale 1ns / 1ps

package gheq_pkg;

    typedef logic [1:0] t_op;

    localparam t_op OP_ACCUMULATE = 2'd0;
    localparam t_op OP_MAP        = 2'd1;
    localparam t_op OP_CLEAR      = 2'd2;

endpackage

@@ rtl/gray_histogram_equalizer_unit.sv @@
// Gray histogram equalizer: accumulate, map and clear on a LEVELS-bin histogram.
// Accumulate reads the bin, then writes it back; clear acts in the idle state;
// map reads and sums the bins up to g, sets up the numerator, runs a serial
// division and then finishes. Reset (synchronous, active low) clears all bin
// valid bits and the pixel total. A finished word waits in an output register
// while the next word is taken. Depends on gheq_pkg.
`timescale 1ns / 1ps

module gray_histogram_equalizer_unit #(
    parameter int LEVELS      = 256,
    parameter int COUNT_WIDTH = 22
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  gheq_pkg::t_op       i_op,
    input  logic [7:0]          i_pixel,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [7:0]          o_equalized
);

    localparam int LW    = (LEVELS > 2) ? $clog2(LEVELS) : 1;
    localparam int CUM_W = COUNT_WIDTH + 8;
    localparam int NUM_W = COUNT_WIDTH + 17;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ACC  = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_SEND = 3'd3;
    localparam logic [2:0] S_DSET = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [COUNT_WIDTH-1:0] r_mem [LEVELS];
    logic [LEVELS-1:0]      r_valid;
    logic [COUNT_WIDTH-1:0] r_rdata;
    logic                   r_rvalid;
    logic [2:0]             r_state;
    logic [LW-1:0]          r_g;
    logic [LW-1:0]          r_idx;
    logic                   r_pend;
    logic [CUM_W-1:0]       r_cum;
    logic [COUNT_WIDTH-1:0] r_total;
    logic [NUM_W-1:0]       r_num;
    logic [COUNT_WIDTH:0]   r_rem;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_ovalid;
    logic [7:0]             r_oeq;

    logic                   acc_in;
    logic [LW-1:0]          lvl;
    logic                   rd_en;
    logic [LW-1:0]          rd_addr;
    logic [COUNT_WIDTH-1:0] rval;
    logic [COUNT_WIDTH:0]   rem_sh;
    logic                   qbit;
    logic [NUM_W-1:0]       qfin;
    logic                   out_free;

    // Limit the pixel to the top level
    assign lvl = (i_pixel > 8'(LEVELS - 1)) ? LW'(LEVELS - 1) : i_pixel[LW-1:0];

    assign o_in_ready = (r_state == S_IDLE);
    assign acc_in     = i_in_valid && o_in_ready;
    assign rd_en      = (acc_in && i_op == gheq_pkg::OP_ACCUMULATE) || (r_state == S_SUM);
    assign rd_addr    = (r_state == S_SUM) ? r_idx : lvl;
    assign rval       = r_rvalid ? r_rdata : '0;
    assign out_free   = !r_ovalid || i_out_ready;

    // Bin memory with registered read
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata  <= r_mem[rd_addr];
            r_rvalid <= r_valid[rd_addr];
        end
        if (r_state == S_ACC) begin
            r_mem[r_g] <= (rval == COUNT_MAX) ? rval : rval + 1'b1;
        end
    end

    // Divider step: shift in one numerator bit, subtract when it fits
    assign rem_sh = {r_rem[COUNT_WIDTH-1:0], r_num[NUM_W-1]};
    assign qbit   = (rem_sh >= {1'b0, r_total});

    // Final quotient
    assign qfin = r_num;

    // Control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_total  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (acc_in) begin
                        r_g <= lvl;
                        case (i_op)
                            gheq_pkg::OP_ACCUMULATE: r_state <= S_ACC;
                            gheq_pkg::OP_MAP: begin
                                r_idx  <= '0;
                                r_pend <= 1'b0;
                                r_cum  <= '0;
                                if (r_total == '0) begin
                                    r_state <= S_FIN;
                                end else begin
                                    r_state <= S_SUM;
                                end
                            end
                            gheq_pkg::OP_CLEAR: begin
                                r_valid <= '0;
                                r_total <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_ACC: begin
                    r_valid[r_g] <= 1'b1;
                    if (r_total != COUNT_MAX) begin
                        r_total <= r_total + 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_SUM: begin
                    if (r_pend) begin
                        r_cum <= r_cum + CUM_W'(rval);
                    end
                    r_pend <= 1'b1;
                    if (r_idx == r_g) begin
                        r_state <= S_SEND;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_SEND: begin
                    r_cum   <= r_cum + CUM_W'(rval);
                    r_state <= S_DSET;
                end
                S_DSET: begin
                    r_num   <= NUM_W'(r_cum) * NUM_W'(LEVELS) + NUM_W'(r_total >> 1);
                    r_rem   <= '0;
                    r_cnt   <= CNT_W'(NUM_W);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= qbit ? rem_sh - {1'b0, r_total} : rem_sh;
                    r_num <= {r_num[NUM_W-2:0], qbit};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // Hold until the output register is free
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        if (r_total == '0 || qfin == '0) begin
                            r_oeq <= '0;
                        end else if (qfin - 1'b1 > NUM_W'(LEVELS - 1)) begin
                            r_oeq <= 8'(LEVELS - 1);
                        end else begin
                            r_oeq <= 8'(qfin - 1'b1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_equalized = r_oeq;

endmodule

@@ rtl/gheq_checker.sv @@
// Port checker for the gray histogram equalizer, bound to the top level.
// Depends on gheq_pkg and gray_histogram_equalizer_unit.
`timescale 1ns / 1ps

module gheq_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input gheq_pkg::t_op i_op,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input logic [7:0]    o_equalized
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_equalized))
        else $error("result word changed while stalled");

    // A map keeps the block busy after it is accepted
    a_map_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_op == gheq_pkg::OP_MAP |=> !o_in_ready)
        else $error("ready during a map");

    // Accumulate blocks for its write-back cycle
    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_op == gheq_pkg::OP_ACCUMULATE |=> !o_in_ready)
        else $error("ready during write-back");

    // No result word right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word after reset");

endmodule

bind gray_histogram_equalizer_unit gheq_checker u_gheq_checker (.*);

@@ verif/gray_histogram_equalizer_checker.sv @@
// Checker for the gray histogram equalizer: watches both channels, predicts
// each equalized word from its own histogram copy and compares. Depends on gheq_pkg.
`timescale 1ns / 1ps

module gray_histogram_equalizer_checker #(
    parameter int LEVELS      = 256,
    parameter int COUNT_WIDTH = 22
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  gheq_pkg::t_op i_op,
    input  logic [7:0]    i_pixel,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  logic [7:0]    i_equalized,
    output int            o_fail_count,
    output int            o_pending
);

    localparam longint COUNT_MAX = (64'd1 << COUNT_WIDTH) - 1;

    longint bin_model [LEVELS];
    longint total_model;
    logic [7:0] equalized_queue [$];

    // Saturate at full scale instead of wrapping.
    function automatic longint bump(input longint v);
        return (v >= COUNT_MAX) ? COUNT_MAX : v + 1;
    endfunction

    function automatic int level_of(input logic [7:0] px);
        return (int'(px) > LEVELS - 1) ? LEVELS - 1 : int'(px);
    endfunction

    // Round LEVELS*cum/total to nearest, subtract one, limit to the level range.
    function automatic logic [7:0] equalize(input int g);
        longint cum;
        longint q;
        cum = 0;
        if (total_model == 0) return 8'd0;
        for (int k = 0; k <= g; k++) cum += bin_model[k];
        q = (longint'(LEVELS) * cum + total_model / 2) / total_model;
        if (q == 0) return 8'd0;
        q = q - 1;
        if (q > LEVELS - 1) q = LEVELS - 1;
        return q[7:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (bin_model[k]) bin_model[k] = 0;
            total_model = 0;
            equalized_queue.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            // Update the model on each accepted input word.
            if (i_in_valid && i_in_ready) begin
                case (i_op)
                    gheq_pkg::OP_ACCUMULATE: begin
                        bin_model[level_of(i_pixel)] = bump(bin_model[level_of(i_pixel)]);
                        total_model = bump(total_model);
                    end
                    gheq_pkg::OP_MAP: equalized_queue.push_back(equalize(level_of(i_pixel)));
                    gheq_pkg::OP_CLEAR: begin
                        foreach (bin_model[k]) bin_model[k] = 0;
                        total_model = 0;
                    end
                    default: ;
                endcase
            end
            // Compare each accepted output word with the oldest prediction.
            if (i_out_valid && i_out_ready) begin
                if (equalized_queue.size() == 0) begin
                    $display("%0t: unexpected word, expected none actual equalized %0d",
                             $time, i_equalized);
                    o_fail_count <= o_fail_count + 1;
                end else if (equalized_queue[0] !== i_equalized) begin
                    $display("%0t: equalized mismatch, expected %0d actual %0d",
                             $time, equalized_queue[0], i_equalized);
                    void'(equalized_queue.pop_front());
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    void'(equalized_queue.pop_front());
                end
            end
            o_pending <= equalized_queue.size();
        end
    end
endmodule

@@ verif/gray_histogram_equalizer_unit_tb.sv @@
// Testbench top for the gray histogram equalizer: drives accumulate, map and
// clear words under several idling phases and gives the verdict.
// Depends on gheq_pkg, gray_histogram_equalizer_unit and its checker.
`timescale 1ns / 1ps

module gray_histogram_equalizer_unit_tb;

    localparam int WATCHDOG_LIMIT = 20000;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_ready;
    gheq_pkg::t_op i_op;
    logic [7:0]    i_pixel;
    logic          o_out_valid;
    logic          i_out_ready;
    logic [7:0]    o_equalized;
    int            fail_count;
    int            pending_words;
    int            send_idle_pct;
    int            stall_pct;
    int            quiet_cycles;

    gray_histogram_equalizer_unit i_dut (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .i_op, .i_pixel,
        .o_out_valid, .i_out_ready, .o_equalized
    );

    gray_histogram_equalizer_checker i_checker (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready), .i_op, .i_pixel,
        .i_out_valid(o_out_valid), .i_out_ready, .i_equalized(o_equalized),
        .o_fail_count(fail_count), .o_pending(pending_words)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Stall the receiver at the rate of the current phase.
    always @(posedge i_clk) begin
        if (!i_rst_n) i_out_ready <= 1'b0;
        else          i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // End the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Drop valid for optional idle gaps, then present one word and hold it
    // until taken; valid stays high for a following word.
    task automatic send_word(input gheq_pkg::t_op op, input logic [7:0] px);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_pixel    <= px;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Mostly runs of accumulates, maps spread in, rare clears and unused codes.
    task automatic send_random(input int count);
        int r;
        logic [7:0] px;
        for (int n = 0; n < count; n++) begin
            r  = $urandom_range(99);
            px = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                          : 8'($urandom_range(100, 160));
            if (r < 62)      send_word(gheq_pkg::OP_ACCUMULATE, px);
            else if (r < 95) send_word(gheq_pkg::OP_MAP, px);
            else if (r < 98) send_word(gheq_pkg::OP_CLEAR, px);
            else             send_word(gheq_pkg::t_op'(2'd3), px);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_op          = gheq_pkg::OP_ACCUMULATE;
        i_pixel       = 8'd0;
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty map, extremes, rounding to zero, unused code, clear.
        send_word(gheq_pkg::OP_MAP, 8'd0);
        send_word(gheq_pkg::OP_MAP, 8'd255);
        send_word(gheq_pkg::OP_ACCUMULATE, 8'd255);
        send_word(gheq_pkg::OP_MAP, 8'd0);
        send_word(gheq_pkg::OP_MAP, 8'd255);
        send_word(gheq_pkg::OP_ACCUMULATE, 8'd0);
        send_word(gheq_pkg::OP_ACCUMULATE, 8'hAA);
        send_word(gheq_pkg::OP_ACCUMULATE, 8'h55);
        send_word(gheq_pkg::OP_MAP, 8'd0);
        send_word(gheq_pkg::OP_MAP, 8'h55);
        send_word(gheq_pkg::OP_MAP, 8'hAA);
        send_word(gheq_pkg::OP_MAP, 8'd254);
        send_word(gheq_pkg::t_op'(2'd3), 8'hFF);
        send_word(gheq_pkg::OP_MAP, 8'd255);
        send_word(gheq_pkg::OP_CLEAR, 8'hFF);
        send_word(gheq_pkg::OP_MAP, 8'd255);
        for (int k = 0; k < 5; k++) send_word(gheq_pkg::OP_ACCUMULATE, 8'd200);
        send_word(gheq_pkg::OP_MAP, 8'd199);
        send_word(gheq_pkg::OP_MAP, 8'd200);
        send_word(gheq_pkg::OP_CLEAR, 8'd0);

        // Hold off the sender until every expected word has come.
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);

        send_random(350);
        send_idle_pct = 76;
        send_random(350);
        send_idle_pct = 0;
        stall_pct     = 76;
        send_random(350);
        send_idle_pct = 37;
        stall_pct     = 37;
        send_random(350);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (fail_count == 0 && pending_words == 0) $display("TEST PASSED");
        else                                       $display("TEST FAILED");
        $finish;
    end
endmodule
